// File: rtl/core/bf3h_pkg.sv
// Shared types, constants and codes for the three-hash Bloom filter.
package bf3h_pkg;

  localparam int unsigned HashW          = 32;
  localparam int unsigned FilterBitsDef  = 65536;
  localparam int unsigned MaxProbesDef   = 16;
  localparam int unsigned FilterSizeW    = 17;
  localparam int unsigned ProbeCountW    = 5;
  localparam int unsigned CfgDataW       = 32;
  localparam int unsigned CfgAddrW       = 3;

  localparam logic [16:0] FilterSizeRst  = 17'd65536;
  localparam logic [4:0]  ProbeCountRst  = 5'd3;

  // hash constants
  localparam logic [31:0] FnvBasis  = 32'd2166136261;
  localparam logic [31:0] FnvPrime  = 32'd16777619;
  localparam logic [31:0] MurSeed   = 32'hdeadbeef;
  localparam logic [31:0] MurC1     = 32'hcc9e2d51;
  localparam logic [31:0] MurC2     = 32'h1b873593;
  localparam logic [31:0] MurMixAdd = 32'he6546b64;
  localparam logic [31:0] MurFin1   = 32'h85ebca6b;
  localparam logic [31:0] MurFin2   = 32'hc2b2ae35;

  // op codes of an input word
  localparam logic [1:0] OpAdd   = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;
  localparam logic [1:0] OpNone  = 2'd3;

  // result kinds
  localparam logic [1:0] KindAdd   = 2'd0;
  localparam logic [1:0] KindQuery = 2'd1;
  localparam logic [1:0] KindClear = 2'd2;

  // register word index (paddr[2])
  localparam logic RegFilterSize = 1'b0;
  localparam logic RegProbeCount = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        maybe_present;
    logic [31:0] items_added;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_ABS,
    ST_MK1,
    ST_MK2,
    ST_MMIX,
    ST_T0,
    ST_T1,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_DIV,
    ST_DWAIT,
    ST_PRB,
    ST_CHK
  } state_e;

endpackage

// File: rtl/core/bloom_filter_three_hash.sv
// Top level of the three-hash Bloom filter: sequencer, hash datapath and bit store.
//
// Usage: a word (op, key_byte, byte_valid, last) is taken when start is high
// and busy is low. Key bytes are hashed by FNV-1a, a Murmur3-style hash and
// one-at-a-time; the op that comes with the last byte picks add or query.
// A result word appears on result_o for one cycle with result_valid_o; the
// receiver cannot stall, so nothing waits on the output side.
// Steps: each byte passes ABS; a byte that completes a 4-byte Murmur word also
// passes MK1, MK2 and MMIX. Key end: finaliser states T0, T1 and F0 to F3, then
// for each of the first three probes the serial remainder unit plus a store
// access, and for each further probe a running modular add plus access.
// A clear sweeps the store one bit a cycle, then gives the result. Reset runs
// the same sweep without a result; busy stays high until the sweep ends.
// The multiplier is one 32x32 unit shared by the FNV and Murmur multiplies; the
// store is a 1-bit-wide RAM with one port, which sets the per-probe cost.
// Registers (APB): 0x0 filter_size, 0x4 probe_count; pready is tied high.
module bloom_filter_three_hash #(
  parameter int unsigned FILTER_BITS = bf3h_pkg::FilterBitsDef,
  parameter int unsigned MAX_PROBES  = bf3h_pkg::MaxProbesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bf3h_pkg::in_word_t            item_i,
  output logic                          result_valid_o,
  output bf3h_pkg::out_word_t           result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bf3h_pkg::CfgAddrW-1:0] paddr,
  input  logic [bf3h_pkg::CfgDataW-1:0] pwdata,
  output logic [bf3h_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned AW = $clog2(FILTER_BITS);
  localparam int unsigned SW = $clog2(FILTER_BITS + 1);
  localparam int unsigned PW = $clog2(MAX_PROBES + 1);

  bf3h_pkg::state_e state_q, state_d;

  // config
  logic [bf3h_pkg::FilterSizeW-1:0] fsize_q, fsize_d;
  logic [bf3h_pkg::ProbeCountW-1:0] pcount_q, pcount_d;
  logic                             cfg_wr;

  // latched word
  logic [1:0]  op_q, op_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;

  // hash state
  logic [31:0] fnv_q, fnv_d;
  logic [31:0] mur_q, mur_d;
  logic [23:0] gather_q, gather_d;
  logic [31:0] oaat_q, oaat_d;
  logic [31:0] len_q, len_d;
  logic [31:0] tmp_q, tmp_d;
  logic [31:0] h1_q, h1_d;
  logic [31:0] h2_q, h2_d;

  // probe state
  logic [AW-1:0] p1_q, p1_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [AW-1:0] probe_q, probe_d;
  logic [PW-1:0] idx_q, idx_d;
  logic          all_q, all_d;
  logic [31:0]   cnt_q, cnt_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic          clr_emit_q, clr_emit_d;

  logic                rvalid_q, rvalid_d;
  bf3h_pkg::out_word_t result_q, result_d;

  // shared units
  logic [31:0] mul_a, mul_b, mul_p;
  logic          div_start, div_done;
  logic [31:0]   div_dvd;
  logic [SW-1:0] div_rem;
  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_addr;

  // effective config
  logic [SW-1:0] size_eff;
  logic [PW-1:0] count_eff;
  logic [4:0]    count_sat;

  // hash helpers
  logic [31:0] sx, o1, o2, mx, fh;
  logic [AW:0] add_b, acc_sum, acc_next;
  logic [AW-1:0] rem_aw;
  logic [5:0]  idx_inc;

  // low 32 bits of the product are all the hashes need
  assign mul_p = mul_a * mul_b;

  always_comb begin
    if (fsize_q == '0 || 32'(fsize_q) > 32'(FILTER_BITS)) begin
      size_eff = SW'(FILTER_BITS);
    end else begin
      size_eff = SW'(fsize_q);
    end
    if (pcount_q == '0) begin
      count_sat = 5'd1;
    end else if (32'(pcount_q) > 32'(MAX_PROBES)) begin
      count_sat = 5'(MAX_PROBES);
    end else begin
      count_sat = pcount_q;
    end
    count_eff = PW'(count_sat);
  end

  assign busy    = (state_q != bf3h_pkg::ST_IDLE);
  assign idx_inc = 6'(idx_q) + 6'd1;
  assign rem_aw  = AW'(div_rem);

  // running (p0 + i*p1) mod size: both operands below size, one subtract
  assign add_b    = (state_q == bf3h_pkg::ST_DWAIT) ? {1'b0, rem_aw} : {1'b0, p1_q};
  assign acc_sum  = {1'b0, acc_q} + add_b;
  assign acc_next = (acc_sum >= (AW+1)'(size_eff)) ? acc_sum - (AW+1)'(size_eff) : acc_sum;

  // one-at-a-time step and Murmur mix
  assign sx = {{24{byte_q[7]}}, byte_q};
  assign o1 = oaat_q + sx;
  assign o2 = o1 + (o1 << 10);
  assign mx = {mur_q[18:0] ^ tmp_q[18:0], mur_q[31:19] ^ tmp_q[31:19]};
  assign fh = mur_q ^ ((len_q[1:0] != 2'd0) ? tmp_q : 32'd0) ^ len_q;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  always_comb begin
    fsize_d  = fsize_q;
    pcount_d = pcount_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        bf3h_pkg::RegFilterSize: fsize_d  = pwdata[bf3h_pkg::FilterSizeW-1:0];
        bf3h_pkg::RegProbeCount: pcount_d = pwdata[bf3h_pkg::ProbeCountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bf3h_pkg::RegFilterSize: prdata = 32'(fsize_q);
      bf3h_pkg::RegProbeCount: prdata = 32'(pcount_q);
      default:                 prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bf3h_pkg::ST_IDLE: begin
        if (start) begin
          if (item_i.op == bf3h_pkg::OpClear) begin
            state_d = bf3h_pkg::ST_CLR;
          end else if (item_i.op == bf3h_pkg::OpNone) begin
            state_d = bf3h_pkg::ST_IDLE;
          end else if (item_i.byte_valid) begin
            state_d = bf3h_pkg::ST_ABS;
          end else if (item_i.last) begin
            state_d = bf3h_pkg::ST_T0;
          end
        end
      end
      bf3h_pkg::ST_CLR: begin
        if (clr_addr_q == AW'(FILTER_BITS - 1)) state_d = bf3h_pkg::ST_IDLE;
      end
      bf3h_pkg::ST_ABS: begin
        if (len_q[1:0] == 2'd3) begin
          state_d = bf3h_pkg::ST_MK1;
        end else begin
          state_d = last_q ? bf3h_pkg::ST_T0 : bf3h_pkg::ST_IDLE;
        end
      end
      bf3h_pkg::ST_MK1:  state_d = bf3h_pkg::ST_MK2;
      bf3h_pkg::ST_MK2:  state_d = bf3h_pkg::ST_MMIX;
      bf3h_pkg::ST_MMIX: state_d = last_q ? bf3h_pkg::ST_T0 : bf3h_pkg::ST_IDLE;
      bf3h_pkg::ST_T0:   state_d = bf3h_pkg::ST_T1;
      bf3h_pkg::ST_T1:   state_d = bf3h_pkg::ST_F0;
      bf3h_pkg::ST_F0:   state_d = bf3h_pkg::ST_F1;
      bf3h_pkg::ST_F1:   state_d = bf3h_pkg::ST_F2;
      bf3h_pkg::ST_F2:   state_d = bf3h_pkg::ST_F3;
      bf3h_pkg::ST_F3:   state_d = bf3h_pkg::ST_DIV;
      bf3h_pkg::ST_DIV:  state_d = bf3h_pkg::ST_DWAIT;
      bf3h_pkg::ST_DWAIT: begin
        if (div_done) state_d = bf3h_pkg::ST_PRB;
      end
      bf3h_pkg::ST_PRB:  state_d = bf3h_pkg::ST_CHK;
      bf3h_pkg::ST_CHK: begin
        if (idx_inc == 6'(count_eff)) begin
          state_d = bf3h_pkg::ST_IDLE;
        end else if (idx_inc < 6'd3) begin
          state_d = bf3h_pkg::ST_DIV;
        end else begin
          state_d = bf3h_pkg::ST_PRB;
        end
      end
      default: state_d = bf3h_pkg::ST_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    op_d       = op_q;
    byte_d     = byte_q;
    last_d     = last_q;
    fnv_d      = fnv_q;
    mur_d      = mur_q;
    gather_d   = gather_q;
    oaat_d     = oaat_q;
    len_d      = len_q;
    tmp_d      = tmp_q;
    h1_d       = h1_q;
    h2_d       = h2_q;
    p1_d       = p1_q;
    acc_d      = acc_q;
    probe_d    = probe_q;
    idx_d      = idx_q;
    all_d      = all_q;
    cnt_d      = cnt_q;
    clr_addr_d = clr_addr_q;
    clr_emit_d = clr_emit_q;
    rvalid_d   = 1'b0;
    result_d   = result_q;
    mul_a      = tmp_q;
    mul_b      = bf3h_pkg::MurC1;
    div_start  = 1'b0;
    div_dvd    = fnv_q;
    ram_we     = 1'b0;
    ram_addr   = probe_q;
    ram_wdata  = 1'b0;

    unique case (state_q)
      bf3h_pkg::ST_IDLE: begin
        if (start) begin
          op_d   = item_i.op;
          byte_d = item_i.key_byte;
          last_d = item_i.last;
          if (item_i.op == bf3h_pkg::OpClear) begin
            // drop the partial key and the count, then sweep the store
            cnt_d      = '0;
            clr_addr_d = '0;
            clr_emit_d = 1'b1;
            fnv_d      = bf3h_pkg::FnvBasis;
            mur_d      = bf3h_pkg::MurSeed;
            gather_d   = '0;
            oaat_d     = '0;
            len_d      = '0;
          end
        end
      end
      bf3h_pkg::ST_CLR: begin
        ram_we     = 1'b1;
        ram_addr   = clr_addr_q;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(FILTER_BITS - 1)) begin
          rvalid_d   = clr_emit_q;
          result_d   = '{result_kind: bf3h_pkg::KindClear, maybe_present: 1'b0,
                         items_added: 32'd0};
          clr_emit_d = 1'b0;
        end
      end
      bf3h_pkg::ST_ABS: begin
        mul_a  = fnv_q ^ {24'd0, byte_q};
        mul_b  = bf3h_pkg::FnvPrime;
        fnv_d  = mul_p;
        oaat_d = o2 ^ (o2 >> 6);
        len_d  = len_q + 32'd1;
        case (len_q[1:0])
          2'd0:    gather_d[7:0]   = gather_q[7:0]   | byte_q;
          2'd1:    gather_d[15:8]  = gather_q[15:8]  | byte_q;
          2'd2:    gather_d[23:16] = gather_q[23:16] | byte_q;
          default: begin
            tmp_d    = {byte_q, gather_q};
            gather_d = '0;
          end
        endcase
      end
      bf3h_pkg::ST_MK1, bf3h_pkg::ST_T0: begin
        mul_a = (state_q == bf3h_pkg::ST_T0) ? {8'd0, gather_q} : tmp_q;
        mul_b = bf3h_pkg::MurC1;
        tmp_d = mul_p;
      end
      bf3h_pkg::ST_MK2, bf3h_pkg::ST_T1: begin
        mul_a = {tmp_q[16:0], tmp_q[31:17]};
        mul_b = bf3h_pkg::MurC2;
        tmp_d = mul_p;
      end
      bf3h_pkg::ST_MMIX: begin
        mur_d = mx + (mx << 2) + bf3h_pkg::MurMixAdd;
      end
      bf3h_pkg::ST_F0: begin
        h1_d = fh ^ (fh >> 16);
        h2_d = oaat_q + (oaat_q << 3);
      end
      bf3h_pkg::ST_F1: begin
        mul_a = h1_q;
        mul_b = bf3h_pkg::MurFin1;
        h1_d  = mul_p;
        h2_d  = h2_q ^ (h2_q >> 11);
      end
      bf3h_pkg::ST_F2: begin
        mul_a = h1_q ^ (h1_q >> 13);
        mul_b = bf3h_pkg::MurFin2;
        h1_d  = mul_p;
        h2_d  = h2_q + (h2_q << 15);
      end
      bf3h_pkg::ST_F3: begin
        h1_d  = h1_q ^ (h1_q >> 16);
        idx_d = '0;
        all_d = 1'b1;
      end
      bf3h_pkg::ST_DIV: begin
        div_start = 1'b1;
        case (idx_inc)
          6'd1:    div_dvd = fnv_q;
          6'd2:    div_dvd = h1_q;
          default: div_dvd = h2_q;
        endcase
      end
      bf3h_pkg::ST_DWAIT: begin
        if (div_done) begin
          probe_d = rem_aw;
          if (idx_q == '0) begin
            acc_d = rem_aw;
          end else if (idx_inc == 6'd2) begin
            p1_d  = rem_aw;
            acc_d = acc_next[AW-1:0];
          end
        end
      end
      bf3h_pkg::ST_PRB: begin
        ram_addr  = probe_q;
        ram_we    = (op_q == bf3h_pkg::OpAdd);
        ram_wdata = 1'b1;
      end
      bf3h_pkg::ST_CHK: begin
        if (op_q == bf3h_pkg::OpQuery && !ram_rdata) all_d = 1'b0;
        if (idx_q != '0) acc_d = acc_next[AW-1:0];
        if (idx_inc == 6'(count_eff)) begin
          if (op_q == bf3h_pkg::OpAdd) cnt_d = cnt_q + 32'd1;
          rvalid_d = 1'b1;
          result_d = '{result_kind: op_q,
                       maybe_present: (op_q == bf3h_pkg::OpQuery) && all_d,
                       items_added: (op_q == bf3h_pkg::OpAdd) ? cnt_q + 32'd1 : cnt_q};
          fnv_d    = bf3h_pkg::FnvBasis;
          mur_d    = bf3h_pkg::MurSeed;
          gather_d = '0;
          oaat_d   = '0;
          len_d    = '0;
        end else begin
          idx_d   = PW'(idx_inc);
          probe_d = acc_next[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bf3h_pkg::ST_CLR;
      fsize_q    <= bf3h_pkg::FilterSizeRst;
      pcount_q   <= bf3h_pkg::ProbeCountRst;
      fnv_q      <= bf3h_pkg::FnvBasis;
      mur_q      <= bf3h_pkg::MurSeed;
      gather_q   <= '0;
      oaat_q     <= '0;
      len_q      <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
      clr_addr_q <= '0;
      clr_emit_q <= 1'b0;
      rvalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      fsize_q    <= fsize_d;
      pcount_q   <= pcount_d;
      fnv_q      <= fnv_d;
      mur_q      <= mur_d;
      gather_q   <= gather_d;
      oaat_q     <= oaat_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      clr_addr_q <= clr_addr_d;
      clr_emit_q <= clr_emit_d;
      rvalid_q   <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    byte_q   <= byte_d;
    last_q   <= last_d;
    tmp_q    <= tmp_d;
    h1_q     <= h1_d;
    h2_q     <= h2_d;
    p1_q     <= p1_d;
    acc_q    <= acc_d;
    probe_q  <= probe_d;
    all_q    <= all_d;
    result_q <= result_d;
  end

  assign result_valid_o = rvalid_q;
  assign result_o       = result_q;

  bf3h_div #(
    .DivW(SW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (size_eff),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  bf3h_ram #(
    .Width(1),
    .Depth(FILTER_BITS)
  ) u_store (
    .clk_i,
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

`ifndef SYNTHESIS
  // a result always closes a busy phase
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result without work");

  // results are single-cycle pulses
  a_result_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result held");

  // a clear always reports an empty count
  a_clear_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.result_kind == bf3h_pkg::KindClear)
      |-> result_o.items_added == 32'd0) else $error("clear count");

  // only queries may report presence
  a_present_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.result_kind != bf3h_pkg::KindQuery)
      |-> !result_o.maybe_present) else $error("presence on non-query");
`endif

endmodule

// File: rtl/core/bf3h_ram.sv
// Generic single-port RAM with registered read.
module bf3h_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bf3h_div.sv
// Bit-serial restoring remainder unit: 32-bit dividend, one bit a cycle.
module bf3h_div #(
  parameter int unsigned DivW = 17
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bf3h_pkg::HashW-1:0]  dividend_i,
  input  logic [DivW-1:0]             divisor_i,
  output logic                        done_o,
  output logic [DivW-1:0]             rem_o
);

  localparam int unsigned StepW = $clog2(bf3h_pkg::HashW);

  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic [StepW-1:0]           step_q, step_d;
  logic [bf3h_pkg::HashW-1:0] dvd_q, dvd_d;
  logic [DivW-1:0]            dvs_q, dvs_d;
  logic [DivW-1:0]            rem_q, rem_d;
  logic [DivW:0]              trial;

  assign trial = {rem_q, dvd_q[bf3h_pkg::HashW-1]};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (run_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DivW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[DivW-1:0];
      end
      dvd_d  = {dvd_q[bf3h_pkg::HashW-2:0], 1'b0};
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(bf3h_pkg::HashW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
